// ===== rtl/first_fit_heap_allocator_core_assert.svh =====
// Assertion macros for the first-fit heap allocator.
// Used by the top level; needs clk and rst in the calling scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFHA_ASSERT_IMPL(lbl, ante, cons, msg)
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

  localparam int unsigned HDR_BYTES      = 32;
  localparam int unsigned MIN_BODY_BYTES = 16;
  localparam int unsigned WANT_W         = 22;  // rounded 21-bit request

  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_IGNORED     = 3'd1;
  localparam logic [2:0] ST_NO_SPACE    = 3'd2;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
  localparam logic [2:0] ST_NOT_BLOCK   = 3'd4;

  // {valid, used}
  localparam logic [1:0] FLAG_NONE = 2'b00;
  localparam logic [1:0] FLAG_FREE = 2'b10;
  localparam logic [1:0] FLAG_USED = 2'b11;

  typedef struct packed {
    logic        func;
    logic [20:0] request_size;
    logic [19:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [19:0] result_offset;
    logic [2:0]  status;
    logic [31:0] double_free_total;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_LOAD, OP_START, OP_SCAN_RD, OP_SCAN_CHK, OP_HEAD,
    OP_RM_RD, OP_RM_WR, OP_CV1, OP_CV2, OP_EX1, OP_EX2, OP_AB_RD, OP_AB_WR,
    OP_F_RD, OP_F_CHK, OP_F_INS, OP_F_NX, OP_F_PV, OP_F_PV2, OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] code;
    logic       give_offset;
  } ctl_t;

  typedef struct packed {
    logic is_free;
    logic zero_size;
    logic null_off;
    logic bad_off;
    logic b_live;
    logic fit;
    logic ext_ok;
    logic carve_ok;
    logic merge;
    logic blk_valid;
    logic blk_used;
    logic clr_done;
  } sts_t;

endpackage

// ===== rtl/ffha_datapath.sv =====
// Datapath of the heap allocator: per-granule block stores, list registers,
// arithmetic and result register. Depends on ffha_pkg; driven by ffha_ctrl.
module ffha_datapath #(
  parameter int unsigned HEAP_BYTES    = 1048576,
  parameter int unsigned INITIAL_BYTES = 65536,
  parameter int unsigned PAGE_BYTES    = 4096,
  parameter int unsigned ALIGN_BYTES   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  ffha_pkg::req_t req,
  input  ffha_pkg::ctl_t ctl,
  output ffha_pkg::sts_t sts,
  output ffha_pkg::rsp_t rsp
);

  localparam int unsigned G  = HEAP_BYTES / 16;
  localparam int unsigned GW = $clog2(G);
  localparam int unsigned LW = GW + 1;
  localparam int unsigned SW = $clog2(HEAP_BYTES);
  localparam int unsigned MW = SW + 1;
  localparam int unsigned AW = ((MW > ffha_pkg::WANT_W) ? MW : ffha_pkg::WANT_W) + 2;
  localparam logic [LW-1:0] NIL = LW'(G);
  localparam logic [AW-1:0] HDR = AW'(ffha_pkg::HDR_BYTES);

  function automatic logic live(input logic [LW-1:0] l);
    return l < NIL;
  endfunction

  function automatic logic [GW-1:0] idx(input logic [LW-1:0] l);
    return l[GW-1:0];
  endfunction

  // block stores
  logic [SW-1:0] size_mem  [G];
  logic [1:0]    flag_mem  [G];
  logic [LW-1:0] aprev_mem [G];
  logic [LW-1:0] anext_mem [G];
  logic [LW-1:0] fprev_mem [G];
  logic [LW-1:0] fnext_mem [G];

  logic [SW-1:0] size_q;
  logic [1:0]    flag_q;
  logic [LW-1:0] aprev_q, anext_q, fprev_q, fnext_q;

  logic          size_we, flag_we, aprev_we, anext_we, fprev_we, fnext_we;
  logic [GW-1:0] size_wa, flag_wa, aprev_wa, anext_wa, fprev_wa, fnext_wa;
  logic [SW-1:0] size_wd;
  logic [1:0]    flag_wd;
  logic [LW-1:0] aprev_wd, anext_wd, fprev_wd, fnext_wd;
  logic [GW-1:0] size_ra, flag_ra, anext_ra, fprev_ra, fnext_ra;

  // registers
  ffha_pkg::req_t              req_r;
  ffha_pkg::rsp_t              rsp_r;
  logic [LW-1:0]               b, nx, pv, ax, an, hd, last;
  logic [MW-1:0]               mtop;
  logic [ffha_pkg::WANT_W-1:0] want;
  logic [SW-1:0]               sb, sx;
  logic [31:0]                 dfc;
  logic [GW-1:0]               clr_cnt;

  // arithmetic
  logic [AW-1:0] w0, want_c, want_a, need, add, r_a, off_a, fb_a;
  logic [LW-1:0] nb, r, cax, can;
  logic [SW-1:0] csx;
  logic          carve_ok, touch;

  always_comb begin
    w0     = (req_r.request_size < 21'(ffha_pkg::MIN_BODY_BYTES)) ?
             AW'(ffha_pkg::MIN_BODY_BYTES) : AW'(req_r.request_size);
    want_c = (w0 + AW'(ALIGN_BYTES - 1)) & ~AW'(ALIGN_BYTES - 1);
    want_a = AW'(want);
    // PAGE_BYTES is a power of two
    need   = HDR + want_a;
    add    = (need + AW'(PAGE_BYTES - 1)) & ~AW'(PAGE_BYTES - 1);
    nb     = LW'(AW'(mtop) >> 4);
    r_a    = AW'(b) + ((want_a + HDR) >> 4);
    r      = LW'(r_a);
    carve_ok = (AW'(sb) >= want_a + HDR + AW'(ffha_pkg::MIN_BODY_BYTES)) &&
               (r_a < AW'(G));
    off_a  = AW'(req_r.payload_offset);
    fb_a   = (off_a - HDR) >> 4;
  end

  // merge candidate: block cax absorbing its address successor can
  always_comb begin
    case (ctl.op)
      ffha_pkg::OP_F_NX: begin
        cax = b;
        can = nx;
        csx = sb;
      end
      ffha_pkg::OP_F_PV2: begin
        cax = pv;
        can = b;
        csx = size_q;
      end
      default: begin
        cax = ax;
        can = an;
        csx = size_q;
      end
    endcase
    touch = ((AW'(cax) << 4) + HDR + AW'(csx)) == (AW'(can) << 4);
  end

  always_comb begin
    sts.is_free   = req_r.func;
    sts.zero_size = req_r.request_size == '0;
    sts.null_off  = req_r.payload_offset == '0;
    sts.bad_off   = (off_a < HDR) || (req_r.payload_offset[3:0] != 4'd0) ||
                    (fb_a >= AW'(G));
    sts.b_live    = live(b);
    sts.fit       = AW'(size_q) >= want_a;
    sts.ext_ok    = (AW'(mtop) + add) <= AW'(HEAP_BYTES);
    sts.carve_ok  = carve_ok;
    sts.merge     = live(cax) && live(can) && !flag_q[0] && touch;
    sts.blk_valid = flag_q[1];
    sts.blk_used  = flag_q[0];
    sts.clr_done  = clr_cnt == GW'(G - 1);
  end

  // store write and read ports
  always_comb begin
    size_we  = 1'b0; size_wa  = '0; size_wd  = '0;
    flag_we  = 1'b0; flag_wa  = '0; flag_wd  = ffha_pkg::FLAG_NONE;
    aprev_we = 1'b0; aprev_wa = '0; aprev_wd = '0;
    anext_we = 1'b0; anext_wa = '0; anext_wd = '0;
    fprev_we = 1'b0; fprev_wa = '0; fprev_wd = '0;
    fnext_we = 1'b0; fnext_wa = '0; fnext_wd = '0;
    size_ra  = idx(b);
    flag_ra  = idx(b);
    anext_ra = idx(b);
    fprev_ra = idx(b);
    fnext_ra = idx(b);
    case (ctl.op)
      ffha_pkg::OP_CLEAR: begin
        flag_we = 1'b1;
        flag_wa = clr_cnt;
        flag_wd = (clr_cnt == '0) ? ffha_pkg::FLAG_FREE : ffha_pkg::FLAG_NONE;
        if (clr_cnt == '0) begin
          size_we  = 1'b1; size_wd = SW'(INITIAL_BYTES - ffha_pkg::HDR_BYTES);
          aprev_we = 1'b1; aprev_wd = NIL;
          anext_we = 1'b1; anext_wd = NIL;
          fprev_we = 1'b1; fprev_wd = NIL;
          fnext_we = 1'b1; fnext_wd = NIL;
        end
      end
      ffha_pkg::OP_RM_WR: begin
        if (live(fprev_q)) begin
          fnext_we = 1'b1; fnext_wa = idx(fprev_q); fnext_wd = fnext_q;
        end
        if (live(fnext_q)) begin
          fprev_we = 1'b1; fprev_wa = idx(fnext_q); fprev_wd = fprev_q;
        end
      end
      ffha_pkg::OP_CV1: begin
        if (carve_ok) begin
          size_we  = 1'b1; size_wa  = idx(r); size_wd = SW'(AW'(sb) - want_a - HDR);
          flag_we  = 1'b1; flag_wa  = idx(r); flag_wd = ffha_pkg::FLAG_FREE;
          aprev_we = 1'b1; aprev_wa = idx(r); aprev_wd = b;
          anext_we = 1'b1; anext_wa = idx(r); anext_wd = nx;
          fprev_we = 1'b1; fprev_wa = idx(r); fprev_wd = NIL;
          fnext_we = 1'b1; fnext_wa = idx(r); fnext_wd = hd;
        end else begin
          flag_we = 1'b1; flag_wa = idx(b); flag_wd = ffha_pkg::FLAG_USED;
        end
      end
      ffha_pkg::OP_CV2: begin
        if (live(nx)) begin
          aprev_we = 1'b1; aprev_wa = idx(nx); aprev_wd = r;
        end
        anext_we = 1'b1; anext_wa = idx(b); anext_wd = r;
        size_we  = 1'b1; size_wa  = idx(b); size_wd  = SW'(want_a);
        if (live(hd)) begin
          fprev_we = 1'b1; fprev_wa = idx(hd); fprev_wd = r;
        end
        flag_we = 1'b1; flag_wa = idx(b); flag_wd = ffha_pkg::FLAG_USED;
      end
      ffha_pkg::OP_EX1: begin
        size_we  = 1'b1; size_wa  = idx(nb); size_wd = SW'(add - HDR);
        flag_we  = 1'b1; flag_wa  = idx(nb); flag_wd = ffha_pkg::FLAG_FREE;
        aprev_we = 1'b1; aprev_wa = idx(nb); aprev_wd = last;
        anext_we = 1'b1; anext_wa = idx(nb); anext_wd = NIL;
        fprev_we = 1'b1; fprev_wa = idx(nb); fprev_wd = NIL;
        fnext_we = 1'b1; fnext_wa = idx(nb); fnext_wd = hd;
        size_ra  = idx(last);
        flag_ra  = idx(last);
      end
      ffha_pkg::OP_EX2: begin
        if (live(ax)) begin
          anext_we = 1'b1; anext_wa = idx(ax); anext_wd = an;
        end
        if (live(hd)) begin
          fprev_we = 1'b1; fprev_wa = idx(hd); fprev_wd = an;
        end
      end
      ffha_pkg::OP_AB_RD: begin
        size_ra  = idx(an);
        anext_ra = idx(an);
        fprev_ra = idx(an);
        fnext_ra = idx(an);
      end
      ffha_pkg::OP_AB_WR: begin
        if (live(fprev_q)) begin
          fnext_we = 1'b1; fnext_wa = idx(fprev_q); fnext_wd = fnext_q;
        end
        if (live(fnext_q)) begin
          fprev_we = 1'b1; fprev_wa = idx(fnext_q); fprev_wd = fprev_q;
        end
        size_we  = 1'b1; size_wa  = idx(ax); size_wd = SW'(AW'(sx) + HDR + AW'(size_q));
        anext_we = 1'b1; anext_wa = idx(ax); anext_wd = anext_q;
        if (live(anext_q)) begin
          aprev_we = 1'b1; aprev_wa = idx(anext_q); aprev_wd = ax;
        end
        flag_we = 1'b1; flag_wa = idx(an); flag_wd = ffha_pkg::FLAG_NONE;
      end
      ffha_pkg::OP_F_CHK: begin
        if (flag_q == ffha_pkg::FLAG_USED) begin
          flag_we  = 1'b1; flag_wa  = idx(b); flag_wd = ffha_pkg::FLAG_FREE;
          fprev_we = 1'b1; fprev_wa = idx(b); fprev_wd = NIL;
          fnext_we = 1'b1; fnext_wa = idx(b); fnext_wd = hd;
        end
      end
      ffha_pkg::OP_F_INS: begin
        if (live(hd)) begin
          fprev_we = 1'b1; fprev_wa = idx(hd); fprev_wd = b;
        end
        flag_ra = idx(nx);
      end
      ffha_pkg::OP_F_PV: begin
        size_ra = idx(pv);
        flag_ra = idx(pv);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    size_q <= size_mem[size_ra];
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    flag_q <= flag_mem[flag_ra];
  end

  always_ff @(posedge clk) begin
    if (aprev_we) aprev_mem[aprev_wa] <= aprev_wd;
    aprev_q <= aprev_mem[idx(b)];
  end

  always_ff @(posedge clk) begin
    if (anext_we) anext_mem[anext_wa] <= anext_wd;
    anext_q <= anext_mem[anext_ra];
  end

  always_ff @(posedge clk) begin
    if (fprev_we) fprev_mem[fprev_wa] <= fprev_wd;
    fprev_q <= fprev_mem[fprev_ra];
  end

  always_ff @(posedge clk) begin
    if (fnext_we) fnext_mem[fnext_wa] <= fnext_wd;
    fnext_q <= fnext_mem[fnext_ra];
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    case (ctl.op)
      ffha_pkg::OP_LOAD: req_r <= req;
      ffha_pkg::OP_START: begin
        want <= ffha_pkg::WANT_W'(want_c);
        b    <= req_r.func ? LW'(fb_a) : hd;
      end
      ffha_pkg::OP_HEAD: b <= hd;
      ffha_pkg::OP_SCAN_CHK: begin
        if (!sts.fit) b <= fnext_q;
      end
      ffha_pkg::OP_RM_WR: begin
        sb <= size_q;
        nx <= anext_q;
      end
      ffha_pkg::OP_EX1: begin
        ax <= last;
        an <= nb;
      end
      ffha_pkg::OP_EX2: sx <= size_q;
      ffha_pkg::OP_F_CHK: begin
        nx <= anext_q;
        pv <= aprev_q;
        sb <= size_q;
      end
      ffha_pkg::OP_F_NX, ffha_pkg::OP_F_PV2: begin
        ax <= cax;
        an <= can;
        sx <= csx;
      end
      ffha_pkg::OP_FIN: begin
        rsp_r.result_offset     <= ctl.give_offset ? 20'((AW'(b) << 4) + HDR) : 20'd0;
        rsp_r.status            <= ctl.code;
        rsp_r.double_free_total <= dfc;
      end
      default: ;
    endcase
  end

  // list and heap control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hd      <= '0;
      last    <= '0;
      mtop    <= MW'(INITIAL_BYTES);
      dfc     <= '0;
      clr_cnt <= '0;
    end else begin
      case (ctl.op)
        ffha_pkg::OP_CLEAR: clr_cnt <= clr_cnt + GW'(1);
        ffha_pkg::OP_RM_WR: begin
          if (!live(fprev_q)) hd <= fnext_q;
        end
        ffha_pkg::OP_CV2: begin
          hd <= r;
          if (b == last) last <= r;
        end
        ffha_pkg::OP_EX2: begin
          last <= an;
          mtop <= MW'(AW'(mtop) + add);
          hd   <= an;
        end
        ffha_pkg::OP_AB_WR: begin
          if (!live(fprev_q)) hd <= fnext_q;
          if (an == last) last <= ax;
        end
        ffha_pkg::OP_F_CHK: begin
          if (flag_q == ffha_pkg::FLAG_FREE && dfc != '1) dfc <= dfc + 32'd1;
        end
        ffha_pkg::OP_F_INS: hd <= b;
        default: ;
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller state machine of the heap allocator: sequences datapath
// operations and runs both handshakes. Depends on ffha_pkg.
module ffha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::ctl_t ctl
);

  typedef enum logic [20:0] {
    S_CLEAR    = 21'h000001,
    S_IDLE     = 21'h000002,
    S_START    = 21'h000004,
    S_SCAN     = 21'h000008,
    S_SCAN_CHK = 21'h000010,
    S_HEAD     = 21'h000020,
    S_RM_RD    = 21'h000040,
    S_RM_WR    = 21'h000080,
    S_CV1      = 21'h000100,
    S_CV2      = 21'h000200,
    S_EX1      = 21'h000400,
    S_EX2      = 21'h000800,
    S_AB_RD    = 21'h001000,
    S_AB_WR    = 21'h002000,
    S_F_RD     = 21'h004000,
    S_F_CHK    = 21'h008000,
    S_F_INS    = 21'h010000,
    S_F_NX     = 21'h020000,
    S_F_PV     = 21'h040000,
    S_F_PV2    = 21'h080000,
    S_FIN      = 21'h100000
  } state_t;

  // where a merge returns to
  typedef enum logic [1:0] {RET_SCAN, RET_PV, RET_FIN} ret_t;

  state_t     state, state_next;
  ret_t       ret, ret_next;
  logic       pass1, pass1_next;
  logic [2:0] code, code_next;
  logic       give, give_next;
  logic       take;

  assign take      = !rsp_valid || rsp_ready;
  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    pass1_next = pass1;
    code_next  = code;
    give_next  = give;
    ctl.op     = ffha_pkg::OP_NOP;
    ctl.code   = code;
    ctl.give_offset = give;
    case (state)
      S_CLEAR: begin
        ctl.op = ffha_pkg::OP_CLEAR;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.op     = ffha_pkg::OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        ctl.op    = ffha_pkg::OP_START;
        give_next = 1'b0;
        if (sts.is_free) begin
          if (sts.null_off) begin
            code_next = ffha_pkg::ST_IGNORED; state_next = S_FIN;
          end else if (sts.bad_off) begin
            code_next = ffha_pkg::ST_NOT_BLOCK; state_next = S_FIN;
          end else begin
            state_next = S_F_RD;
          end
        end else if (sts.zero_size) begin
          code_next = ffha_pkg::ST_IGNORED; state_next = S_FIN;
        end else begin
          pass1_next = 1'b0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.op = ffha_pkg::OP_SCAN_RD;
        if (!sts.b_live) begin
          if (pass1 || !sts.ext_ok) begin
            code_next = ffha_pkg::ST_NO_SPACE; state_next = S_FIN;
          end else begin
            state_next = S_EX1;
          end
        end else begin
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        ctl.op     = ffha_pkg::OP_SCAN_CHK;
        state_next = sts.fit ? S_RM_RD : S_SCAN;
      end
      S_HEAD: begin
        ctl.op = ffha_pkg::OP_HEAD; state_next = S_SCAN;
      end
      S_RM_RD: begin
        ctl.op = ffha_pkg::OP_RM_RD; state_next = S_RM_WR;
      end
      S_RM_WR: begin
        ctl.op = ffha_pkg::OP_RM_WR; state_next = S_CV1;
      end
      S_CV1: begin
        ctl.op = ffha_pkg::OP_CV1;
        if (sts.carve_ok) begin
          state_next = S_CV2;
        end else begin
          code_next = ffha_pkg::ST_DONE; give_next = 1'b1; state_next = S_FIN;
        end
      end
      S_CV2: begin
        ctl.op    = ffha_pkg::OP_CV2;
        code_next = ffha_pkg::ST_DONE; give_next = 1'b1; state_next = S_FIN;
      end
      S_EX1: begin
        ctl.op = ffha_pkg::OP_EX1; state_next = S_EX2;
      end
      S_EX2: begin
        ctl.op     = ffha_pkg::OP_EX2;
        pass1_next = 1'b1;
        if (sts.merge) begin
          ret_next = RET_SCAN; state_next = S_AB_RD;
        end else begin
          state_next = S_HEAD;
        end
      end
      S_AB_RD: begin
        ctl.op = ffha_pkg::OP_AB_RD; state_next = S_AB_WR;
      end
      S_AB_WR: begin
        ctl.op = ffha_pkg::OP_AB_WR;
        case (ret)
          RET_SCAN: state_next = S_HEAD;
          RET_PV:   state_next = S_F_PV;
          default: begin
            code_next = ffha_pkg::ST_DONE; state_next = S_FIN;
          end
        endcase
      end
      S_F_RD: begin
        ctl.op = ffha_pkg::OP_F_RD; state_next = S_F_CHK;
      end
      S_F_CHK: begin
        ctl.op = ffha_pkg::OP_F_CHK;
        if (!sts.blk_valid) begin
          code_next = ffha_pkg::ST_NOT_BLOCK; state_next = S_FIN;
        end else if (!sts.blk_used) begin
          code_next = ffha_pkg::ST_DOUBLE_FREE; state_next = S_FIN;
        end else begin
          state_next = S_F_INS;
        end
      end
      S_F_INS: begin
        ctl.op = ffha_pkg::OP_F_INS; state_next = S_F_NX;
      end
      S_F_NX: begin
        ctl.op = ffha_pkg::OP_F_NX;
        if (sts.merge) begin
          ret_next = RET_PV; state_next = S_AB_RD;
        end else begin
          state_next = S_F_PV;
        end
      end
      S_F_PV: begin
        ctl.op = ffha_pkg::OP_F_PV; state_next = S_F_PV2;
      end
      S_F_PV2: begin
        ctl.op = ffha_pkg::OP_F_PV2;
        if (sts.merge) begin
          ret_next = RET_FIN; state_next = S_AB_RD;
        end else begin
          code_next = ffha_pkg::ST_DONE; state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (take) begin
          ctl.op = ffha_pkg::OP_FIN; state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret       <= RET_FIN;
      pass1     <= 1'b0;
      code      <= ffha_pkg::ST_DONE;
      give      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      pass1 <= pass1_next;
      code  <= code_next;
      give  <= give_next;
      if (state == S_FIN && take) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath and the assertion header.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   req     | req_valid/req_ready  | func, request_size, payload_offset
//   rsp     | rsp_valid/rsp_ready  | result_offset, status, double_free_total
//
// A zero size, null or misaligned offset goes straight to the result.
// An allocate takes the first free-list block that fits, split if large
// enough; if none fits it grows the heap (merging a free tail) and walks
// again, and reports out of space if growth or the second walk fails. A
// free reports a non-block or double free, else merges with free neighbors.
// After reset a clearing pass sweeps the block flag store;
// req_ready stays low until it ends.
// A result waits in the output register; a new transaction is taken
// meanwhile and stalls at its end until the register is free.
`include "first_fit_heap_allocator_core_assert.svh"
module first_fit_heap_allocator_core #(
  parameter int unsigned HEAP_BYTES    = 1048576,
  parameter int unsigned INITIAL_BYTES = 65536,
  parameter int unsigned PAGE_BYTES    = 4096,
  parameter int unsigned ALIGN_BYTES   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ffha_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ffha_pkg::rsp_t rsp
);

  ffha_pkg::ctl_t ctl;
  ffha_pkg::sts_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ffha_datapath #(
    .HEAP_BYTES    (HEAP_BYTES),
    .INITIAL_BYTES (INITIAL_BYTES),
    .PAGE_BYTES    (PAGE_BYTES),
    .ALIGN_BYTES   (ALIGN_BYTES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .ctl (ctl),
    .sts (sts),
    .rsp (rsp)
  );

  `FFHA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
  `FFHA_ASSERT_IMPL(a_offset_only_done, rsp_valid && rsp.status != ffha_pkg::ST_DONE, rsp.result_offset == '0, "offset on failure")
  `FFHA_ASSERT_IMPL(a_double_counted, rsp_valid && rsp.status == ffha_pkg::ST_DOUBLE_FREE, rsp.double_free_total != '0, "double free not counted")
  `FFHA_ASSERT_IMPL(a_no_accept_clear, ctl.op == ffha_pkg::OP_CLEAR, !req_ready, "ready during clear")

endmodule

// ===== sim/tb_first_fit_heap_allocator_core.sv =====
// Testbench for first_fit_heap_allocator_core: directed and random allocate/free traffic
// checked against an in-bench heap predictor. Depends on ffha_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator_core;

  localparam int unsigned HEAP    = 1048576;
  localparam int unsigned INITIAL = 65536;
  localparam int unsigned PAGE    = 4096;
  localparam int unsigned ALIGN   = 16;
  localparam int unsigned GRAN    = HEAP / 16;
  localparam int unsigned NIL     = GRAN;
  localparam int unsigned HDR     = ffha_pkg::HDR_BYTES;
  localparam int unsigned MIN_BODY = ffha_pkg::MIN_BODY_BYTES;
  localparam int unsigned N_RANDOM = 2000;
  localparam int unsigned CALM_TAIL = 200;
  localparam int unsigned WATCHDOG_LIMIT = 500000;  // covers the clearing pass after reset

  class heap_scoreboard;
    int unsigned bsize[GRAN];
    bit          bvalid[GRAN];
    bit          bused[GRAN];
    int unsigned aprev[GRAN], anext[GRAN], fnext[GRAN], fprev[GRAN];
    int unsigned fl_head, last_blk, top, dfree_cnt;
    ffha_pkg::rsp_t due_q[$];
    int unsigned live_offs[$];
    int unsigned freed_offs[$];
    int unsigned errors, checked;
    int unsigned status_seen[5];

    function void clear();
      for (int i = 0; i < GRAN; i++) begin
        bsize[i] = 0; bvalid[i] = 0; bused[i] = 0;
        aprev[i] = 0; anext[i] = 0; fnext[i] = 0; fprev[i] = 0;
      end
      bsize[0] = INITIAL - HDR;
      bvalid[0] = 1;
      aprev[0] = NIL; anext[0] = NIL; fnext[0] = NIL; fprev[0] = NIL;
      fl_head = 0; last_blk = 0; top = INITIAL; dfree_cnt = 0;
    endfunction

    function bit is_blk(int unsigned g);
      return g < GRAN;
    endfunction

    function void free_push(int unsigned b);
      fprev[b] = NIL;
      fnext[b] = fl_head;
      if (is_blk(fl_head)) fprev[fl_head] = b;
      fl_head = b;
    endfunction

    function void free_unlink(int unsigned b);
      int unsigned p, n;
      p = fprev[b];
      n = fnext[b];
      if (is_blk(p)) fnext[p] = n; else fl_head = n;
      if (is_blk(n)) fprev[n] = p;
    endfunction

    function bit adjacent(int unsigned a, int unsigned b);
      return longint'(a) * 16 + HDR + bsize[a] == longint'(b) * 16;
    endfunction

    function void absorb_succ(int unsigned b);
      int unsigned n, nn;
      n = anext[b];
      if (!is_blk(n)) return;
      nn = anext[n];
      free_unlink(n);
      bsize[b] += HDR + bsize[n];
      anext[b] = nn;
      if (is_blk(nn)) aprev[nn] = b;
      if (n == last_blk) last_blk = b;
      bvalid[n] = 0;
      bused[n] = 0;
    endfunction

    function void split(int unsigned b, int unsigned want);
      int unsigned r, nx;
      if (longint'(bsize[b]) < longint'(want) + HDR + MIN_BODY) return;
      r = b + (HDR + want) / 16;
      if (!is_blk(r)) return;
      nx = anext[b];
      bsize[r] = bsize[b] - want - HDR;
      bvalid[r] = 1;
      bused[r] = 0;
      aprev[r] = b;
      anext[r] = nx;
      if (is_blk(nx)) aprev[nx] = r;
      anext[b] = r;
      if (b == last_blk) last_blk = r;
      bsize[b] = want;
      free_push(r);
    endfunction

    function bit grow(int unsigned want);
      longint add;
      int unsigned b, p;
      add = ((longint'(HDR) + want + PAGE - 1) / PAGE) * PAGE;
      if (longint'(top) + add > HEAP) return 0;
      b = top / 16;
      if (!is_blk(b)) return 0;
      p = last_blk;
      bsize[b] = int'(add) - HDR;
      bvalid[b] = 1;
      bused[b] = 0;
      aprev[b] = p;
      anext[b] = NIL;
      if (is_blk(p)) anext[p] = b;
      last_blk = b;
      top += int'(add);
      free_push(b);
      if (is_blk(p) && !bused[p] && adjacent(p, b)) absorb_succ(p);
      return 1;
    endfunction

    function void allocate(int unsigned size, output int unsigned off, output logic [2:0] st);
      int unsigned want, b;
      off = 0;
      if (size == 0) begin
        st = ffha_pkg::ST_IGNORED;
        return;
      end
      want = size < MIN_BODY ? MIN_BODY : size;
      want = (want + ALIGN - 1) / ALIGN * ALIGN;
      for (int pass = 0; pass < 2; pass++) begin
        b = fl_head;
        while (is_blk(b)) begin
          if (bsize[b] >= want) begin
            free_unlink(b);
            split(b, want);
            bused[b] = 1;
            st = ffha_pkg::ST_DONE;
            off = b * 16 + HDR;
            return;
          end
          b = fnext[b];
        end
        if (pass == 1 || !grow(want)) break;
      end
      st = ffha_pkg::ST_NO_SPACE;
    endfunction

    function logic [2:0] release_blk(int unsigned off);
      int unsigned b, nx, pv;
      if (off == 0) return ffha_pkg::ST_IGNORED;
      if (off < HDR || ((off - HDR) & 15) != 0) return ffha_pkg::ST_NOT_BLOCK;
      b = (off - HDR) / 16;
      if (!is_blk(b) || !bvalid[b]) return ffha_pkg::ST_NOT_BLOCK;
      if (!bused[b]) begin
        if (dfree_cnt != 32'hFFFF_FFFF) dfree_cnt++;
        return ffha_pkg::ST_DOUBLE_FREE;
      end
      bused[b] = 0;
      free_push(b);
      nx = anext[b];
      if (is_blk(nx) && !bused[nx] && adjacent(b, nx)) absorb_succ(b);
      pv = aprev[b];
      if (is_blk(pv) && !bused[pv] && adjacent(pv, b)) absorb_succ(pv);
      return ffha_pkg::ST_DONE;
    endfunction

    // predict one transaction and keep the live/freed offset pools in step
    function void note(ffha_pkg::req_t r);
      ffha_pkg::rsp_t e;
      int unsigned off;
      int idx[$];
      e = '0;
      if (r.func == 1'b0) begin
        allocate(r.request_size, off, e.status);
        e.result_offset = off[19:0];
        if (e.status == ffha_pkg::ST_DONE) live_offs.push_back(off);
      end else begin
        e.status = release_blk(r.payload_offset);
        if (e.status == ffha_pkg::ST_DONE) begin
          idx = live_offs.find_first_index(x) with (x == r.payload_offset);
          if (idx.size() != 0) live_offs.delete(idx[0]);
          freed_offs.push_back(r.payload_offset);
          if (freed_offs.size() > 16) void'(freed_offs.pop_front());
        end
      end
      e.double_free_total = dfree_cnt;
      status_seen[e.status]++;
      due_q.push_back(e);
    endfunction

    function void mismatch(string what, ffha_pkg::rsp_t e, ffha_pkg::rsp_t g);
      errors++;
      if (errors <= 10)
        $display("%0t mismatch %s: exp off=%0h st=%0d dft=%0d, got off=%0h st=%0d dft=%0d",
                 $time, what, e.result_offset, e.status, e.double_free_total,
                 g.result_offset, g.status, g.double_free_total);
    endfunction

    function void check(ffha_pkg::rsp_t got);
      ffha_pkg::rsp_t e;
      if (due_q.size() == 0) begin
        mismatch("unexpected transaction", '0, got);
        return;
      end
      e = due_q.pop_front();
      checked++;
      if (got.result_offset != e.result_offset) mismatch("result_offset", e, got);
      if (got.status != e.status) mismatch("status", e, got);
      if (got.double_free_total != e.double_free_total) mismatch("double_free_total", e, got);
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  ffha_pkg::req_t req;
  ffha_pkg::rsp_t rsp;
  heap_scoreboard sb;
  bit long_hold, hold_done, calm;
  int unsigned idle_cycles, sent;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function ffha_pkg::req_t mk_alloc(int unsigned size);
    ffha_pkg::req_t r;
    r = '0;
    r.func = 1'b0;
    r.request_size = size[20:0];
    return r;
  endfunction

  function ffha_pkg::req_t mk_free(int unsigned off);
    ffha_pkg::req_t r;
    r = '0;
    r.func = 1'b1;
    r.payload_offset = off[19:0];
    return r;
  endfunction

  function ffha_pkg::req_t directed_item(int i);
    int unsigned n;
    n = sb.live_offs.size();
    case (i)
      0: return mk_alloc(0);
      1: return mk_free(0);
      2: return mk_alloc(1);
      3: return mk_alloc(16);
      4: return mk_alloc(17);
      5: return mk_alloc(1048576);
      6: return mk_alloc(1048575);
      7: return mk_free(16);
      8: return mk_free(33);
      9: return mk_free(20'hFFFFF);
      10: return n ? mk_free(sb.live_offs[0] + 16) : mk_alloc(5);  // inside a payload
      11: return n ? mk_free(sb.live_offs[0]) : mk_alloc(5);
      12: return sb.freed_offs.size() ? mk_free(sb.freed_offs[$]) : mk_alloc(5);
      13: return mk_alloc(100000);  // forces growth
      14: return mk_alloc(70000);
      15: return n ? mk_free(sb.live_offs[n-1]) : mk_alloc(5);
      16: return n ? mk_free(sb.live_offs[0]) : mk_alloc(5);
      17: return mk_alloc(32);
      18: return mk_alloc(4000);
      19: return n ? mk_free(sb.live_offs[n/2]) : mk_alloc(5);
      default: return mk_alloc(24);
    endcase
  endfunction

  function ffha_pkg::req_t random_item();
    int unsigned n, pick;
    n = sb.live_offs.size();
    pick = $urandom_range(0, 99);
    if (pick < 6) return mk_free($urandom_range(0, 20'hFFFFF));
    if (pick < 9 && sb.freed_offs.size() != 0)
      return mk_free(sb.freed_offs[$urandom_range(0, sb.freed_offs.size() - 1)]);
    if (pick < 10) return $urandom_range(0, 1) ? mk_alloc(0) : mk_free(0);
    if (n != 0 && (n > 48 || pick < 50))
      return mk_free(sb.live_offs[$urandom_range(0, n - 1)]);
    if (pick < 94) return mk_alloc($urandom_range(1, 1024));
    if (pick < 99) return mk_alloc($urandom_range(1, 65536));
    return mk_alloc($urandom_range(1, 1048576));
  endfunction

  task automatic send(ffha_pkg::req_t item);
    int unsigned gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_valid = 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    req = item;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note(item);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    long_hold = 1'b0;
    calm = 1'b0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < 20; i++) send(directed_item(i));
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) long_hold = 1'b1;
      if (i == 900) begin
        req_valid = 1'b0;
        while (sb.due_q.size() != 0) @(negedge clk);
      end
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      send(random_item());
    end
    req_valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Sent %0d transactions, checked %0d results, %0d mismatches.",
             sent, sb.checked, sb.errors);
    $display("Status mix: done %0d, ignored %0d, no space %0d, double free %0d, not a block %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // output side: random stall bursts, one long hold-off, none in the calm tail
  initial begin
    rsp_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        rsp_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end else if (!rst && !calm && $urandom_range(0, 9) == 0) begin
        rsp_ready = 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        rsp_ready = !rst;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
